FILE: src/htmp_pkg.sv
// shared types and constants for the hex text midi message parser
package htmp_pkg;

   // widths of the stream data buses
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // default depth of the queue between front and back
   localparam int FIFO_DEPTH = 2;

   // character kinds found by the front end
   typedef enum logic [2:0] {
      KIND_DIGIT,
      KIND_SPACE,
      KIND_PLUS,
      KIND_MINUS,
      KIND_X,
      KIND_NUL,
      KIND_OTHER
   } char_kind_type;

   // one classified character as it sits in the queue
   typedef struct packed {
      char_kind_type kind;
      logic [3:0]    digit;
      logic          last;
   } char_item_type;

endpackage

FILE: src/hex_text_midi_message_parser_top.sv
// top level of the hex text midi message parser
// the last character passes through a queue slot and then the result register before the result shows on rsp_tvalid
// throughput: one character per cycle while the queue is not full, limited by the token scanner step
// a waiting result holds the next body's last character; the queue then fills and stalls req
// reset: synchronous, active high; clears the queue, the scanner state and the result valid
module hex_text_midi_message_parser_top #(
   parameter int FifoDepth = htmp_pkg::FIFO_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [htmp_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] text_char
   input  logic                            req_tlast,   // is_last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] accepted, [2:1] message_length, [10:3] status_byte,
   // [18:11] first_data, [26:19] second_data, [31:27] zero
   output logic [htmp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import htmp_pkg::*;

   char_item_type front_item;
   char_item_type queue_item;
   logic          queue_valid;
   logic          queue_take;

   // front end
   htmp_classify u_classify (
      .text_char (req_tdata),
      .is_last   (req_tlast),
      .item      (front_item)
   );

   // decoupling queue
   htmp_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_item (front_item),
      .not_full  (req_tready),
      .pop       (queue_take),
      .pop_item  (queue_item),
      .not_empty (queue_valid)
   );

   // back end
   htmp_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (queue_item),
      .item_take  (queue_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: src/htmp_classify.sv
// front end: sorts each incoming character into a kind and a hex digit value
module htmp_classify (
   input  logic [7:0]            text_char,
   input  logic                  is_last,
   output htmp_pkg::char_item_type item
);
   import htmp_pkg::*;

   // kind and nibble value of the character
   always_comb begin
      item.last  = is_last;
      item.digit = 4'd0;
      if (text_char inside {[8'h30:8'h39]}) begin
         item.kind  = KIND_DIGIT;
         item.digit = text_char[3:0];
      end else if (text_char inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         item.kind  = KIND_DIGIT;
         item.digit = 4'(text_char[3:0] + 4'd9);
      end else if (text_char inside {8'h20, [8'h09:8'h0D]}) begin
         item.kind = KIND_SPACE;
      end else if (text_char == 8'h2B) begin
         item.kind = KIND_PLUS;
      end else if (text_char == 8'h2D) begin
         item.kind = KIND_MINUS;
      end else if (text_char inside {8'h78, 8'h58}) begin
         item.kind = KIND_X;
      end else if (text_char == 8'h00) begin
         item.kind = KIND_NUL;
      end else begin
         item.kind = KIND_OTHER;
      end
   end

endmodule

FILE: src/htmp_fifo.sv
// short queue of classified characters between front and back
module htmp_fifo #(
   parameter int Depth = htmp_pkg::FIFO_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  htmp_pkg::char_item_type push_item,
   output logic                    not_full,
   input  logic                    pop,
   output htmp_pkg::char_item_type pop_item,
   output logic                    not_empty
);
   import htmp_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   char_item_type      slot_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign not_full  = (count_ff != CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_item  = slot_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CntW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CntW'(count_ff - 1'b1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/htmp_scan.sv
// back end: token scanner, byte store, message check and result register
module htmp_scan (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   input  htmp_pkg::char_item_type            item,
   output logic                               item_take,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [htmp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import htmp_pkg::*;

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_SIGN    = 3'd1,
      MODE_ZERO    = 3'd2,
      MODE_ZEROX   = 3'd3,
      MODE_DIGITS  = 3'd4
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] value;
      logic       overflow;
      logic       negative;
      logic [2:0] found;
      logic [7:0] store0;
      logic [7:0] store1;
      logic [7:0] store2;
      logic       failed;
      logic       stopped;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      mode: MODE_BETWEEN, value: 8'd0, overflow: 1'b0, negative: 1'b0, found: 3'd0,
      store0: 8'd0, store1: 8'd0, store2: 8'd0, failed: 1'b0, stopped: 1'b0};

   scan_state_type             scan_ff, scan_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   // close the current token and file its byte
   function automatic scan_state_type finish_token(input scan_state_type s);
      scan_state_type r;
      r = s;
      if (s.overflow || (s.negative && s.value != 8'd0)) begin
         r.failed = 1'b1;
      end else begin
         case (s.found)
            3'd0:    r.store0 = s.value;
            3'd1:    r.store1 = s.value;
            3'd2:    r.store2 = s.value;
            default: r.store0 = s.store0;
         endcase
         r.found = 3'(s.found + 1'b1);
         if (r.found >= 3'd4) begin
            r.stopped = 1'b1;
         end
      end
      r.mode     = MODE_BETWEEN;
      r.value    = 8'd0;
      r.overflow = 1'b0;
      r.negative = 1'b0;
      return r;
   endfunction

   // first digit of a token
   function automatic scan_state_type start_digit(input scan_state_type s,
                                                  input logic [3:0] d);
      scan_state_type r;
      r          = s;
      r.value    = {4'd0, d};
      r.overflow = 1'b0;
      r.mode     = (d == 4'd0) ? MODE_ZERO : MODE_DIGITS;
      return r;
   endfunction

   // character seen where a token may begin
   function automatic scan_state_type scan_between(input scan_state_type s,
                                                   input char_item_type c);
      scan_state_type r;
      r = s;
      case (c.kind)
         KIND_NUL:   r.stopped = 1'b1;
         KIND_SPACE: r.mode = s.mode;
         KIND_DIGIT: begin
            r.negative = 1'b0;
            r = start_digit(r, c.digit);
         end
         KIND_PLUS, KIND_MINUS: begin
            r.negative = (c.kind == KIND_MINUS);
            r.value    = 8'd0;
            r.overflow = 1'b0;
            r.mode     = MODE_SIGN;
         end
         default:    r.failed = 1'b1;
      endcase
      return r;
   endfunction

   // one character through the scanner
   function automatic scan_state_type scan_char(input scan_state_type s,
                                                input char_item_type c);
      scan_state_type r;
      logic           is_dig;
      r      = s;
      is_dig = (c.kind == KIND_DIGIT);
      if (!(s.failed || s.stopped)) begin
         case (s.mode)
            MODE_ZEROX: begin
               if (is_dig) begin
                  r.value = {4'd0, c.digit};
                  r.mode  = MODE_DIGITS;
               end else begin
                  r.failed = 1'b1;
               end
            end
            MODE_SIGN: begin
               if (is_dig) begin
                  r = start_digit(s, c.digit);
               end else begin
                  r.failed = 1'b1;
               end
            end
            MODE_ZERO, MODE_DIGITS: begin
               if (s.mode == MODE_ZERO && c.kind == KIND_X) begin
                  r.mode = MODE_ZEROX;
               end else if (is_dig) begin
                  if (s.value >= 8'h10) begin
                     r.overflow = 1'b1;
                  end
                  r.value = {s.value[3:0], c.digit};
                  r.mode  = MODE_DIGITS;
               end else begin
                  r = finish_token(s);
                  if (!(r.failed || r.stopped)) begin
                     r = scan_between(r, c);
                  end
               end
            end
            default:    r = scan_between(s, c);
         endcase
      end
      return r;
   endfunction

   // last items wait for a free result register, others always go
   assign item_take = item_valid && (!item.last || !rsp_valid_ff || rsp_tready);

   // next scanner state and result
   always_comb begin
      scan_state_type s;
      logic [3:0]     hi;
      logic [1:0]     expected;
      logic           ok;
      s            = scan_ff;
      hi           = 4'd0;
      expected     = 2'd3;
      ok           = 1'b0;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (item_take) begin
         s = scan_char(scan_ff, item);
         if (item.last) begin
            // close whatever token is still open
            if (!s.failed && !s.stopped) begin
               if (s.mode == MODE_SIGN || s.mode == MODE_ZEROX) begin
                  s.failed = 1'b1;
               end else if (s.mode == MODE_ZERO || s.mode == MODE_DIGITS) begin
                  s = finish_token(s);
               end
            end
            // channel message check
            hi       = s.store0[7:4];
            expected = (hi == 4'hC || hi == 4'hD) ? 2'd2 : 2'd3;
            ok       = !s.failed && s.found != 3'd0 && s.store0[7] && hi != 4'hF
                       && s.found == {1'b0, expected} && !s.store1[7]
                       && (expected == 2'd2 || !s.store2[7]);
            rsp_valid_in = 1'b1;
            rsp_data_in  = {5'd0, s.store2, s.store1, s.store0,
                            ok ? expected : 2'd0, ok};
            scan_in      = SCAN_RESET;
         end else begin
            scan_in = s;
         end
      end
   end

   // scanner state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= SCAN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: src/htmp_checker.sv
// port-level checks for the parser top level and their bind
module htmp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [htmp_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [htmp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // an item offered and not taken is held by the sender
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tlast))
      else $error("request changed while stalled");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // accepted results carry a length of two or three, rejected ones zero
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] ? (rsp_tdata[2:1] == 2'd2 || rsp_tdata[2:1] == 2'd3)
                                   : (rsp_tdata[2:1] == 2'd0)))
      else $error("accepted flag and length disagree");

   // accepted status is a channel status and the length fits it
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         rsp_tdata[10] && rsp_tdata[10:7] != 4'hF
         && ((rsp_tdata[10:7] == 4'hC || rsp_tdata[10:7] == 4'hD) == (rsp_tdata[2:1] == 2'd2)))
      else $error("accepted result with bad status or length");

   // accepted data bytes are below 0x80, and a two byte message leaves the third byte clear
   a_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         !rsp_tdata[18] && (rsp_tdata[2:1] == 2'd3 ? !rsp_tdata[26] : rsp_tdata[26:19] == 8'd0))
      else $error("accepted result with bad data bytes");

endmodule

bind hex_text_midi_message_parser_top htmp_checker u_htmp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
